// ===== src/tecc_pkg.sv =====
// Shared codes, field widths and types for the labeler of components left once all bridges are cut.
package tecc_pkg;

  localparam int FW = 15;
  localparam int TW = 15;
  localparam int OPW = 2;
  localparam int STW = 2;
  localparam int IN_DW = 48;
  localparam int OUT_DW = 32;

  localparam logic [OPW-1:0] OP_ADD = 2'd0;
  localparam logic [OPW-1:0] OP_RUN = 2'd1;
  localparam logic [OPW-1:0] OP_READ = 2'd2;

  localparam logic [STW-1:0] ST_OK = 2'd0;
  localparam logic [STW-1:0] ST_FULL = 2'd1;
  localparam logic [STW-1:0] ST_RANGE = 2'd2;
  localparam logic [STW-1:0] ST_NOT_RUN = 2'd3;

  typedef struct packed {
    logic          lt;
    logic [TW-1:0] mn;
  } cmp_res_t;

endpackage

// ===== src/tecc_cmp.sv =====
// Shared compare and minimum unit used by the walk and count steps.
module tecc_cmp (
  input  logic [tecc_pkg::TW-1:0] x,
  input  logic [tecc_pkg::TW-1:0] y,
  output tecc_pkg::cmp_res_t      res
);

  always_comb begin
    res.lt = (x < y);
    res.mn = (x < y) ? x : y;
  end

endmodule

// ===== src/two_edge_connected_components.sv =====
// Top level: edge store, depth-first walk sequencer and label memories.
// A stored edge add passes through S_DISP and S_ADD0 to S_ADD3, a valid label read through S_DISP
// and S_QRY, before S_OUT hands the result on. A run is carried out by the walk sequencer, which
// reads the edge store and label memories step by step through a single shared comparator.
// After reset a clearing pass over all MAX_VERTICES entries empties the adjacency lists; no beat is
// accepted meanwhile. Reset is synchronous and active low; configuration writes are always taken.
module two_edge_connected_components #(
  parameter int MAX_VERTICES = 16384,
  parameter int MAX_EDGES = 32768
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [tecc_pkg::FW-1:0]       cfg_wr_data,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // Fields from bit 0: end_a, end_b, query_vertex, zero fill.
  input  logic [tecc_pkg::IN_DW-1:0]    in_tdata,
  // Fields from bit 0: operation.
  input  logic [tecc_pkg::OPW-1:0]      in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // Fields from bit 0: component_count, vertex_label, zero fill.
  output logic [tecc_pkg::OUT_DW-1:0]   out_tdata,
  // Fields from bit 0: status.
  output logic [tecc_pkg::STW-1:0]      out_tuser
);

  localparam int FW = tecc_pkg::FW;
  localparam int TW = tecc_pkg::TW;
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int HW = $clog2(2 * MAX_EDGES);
  localparam int PW = HW + 1;
  localparam int EW = $clog2(MAX_EDGES + 1);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int LW = (NW > FW) ? NW : FW;
  localparam int SPW = NW;

  localparam logic [4:0] S_INIT = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_DISP = 5'd2;
  localparam logic [4:0] S_ADD0 = 5'd3;
  localparam logic [4:0] S_ADD1 = 5'd4;
  localparam logic [4:0] S_ADD2 = 5'd5;
  localparam logic [4:0] S_ADD3 = 5'd6;
  localparam logic [4:0] S_RCLR = 5'd7;
  localparam logic [4:0] S_TO_RD = 5'd8;
  localparam logic [4:0] S_TO_CHK = 5'd9;
  localparam logic [4:0] S_TW_STEP = 5'd10;
  localparam logic [4:0] S_TW_POP = 5'd11;
  localparam logic [4:0] S_TW_EDGE = 5'd12;
  localparam logic [4:0] S_TW_VIS = 5'd13;
  localparam logic [4:0] S_LO_RD = 5'd14;
  localparam logic [4:0] S_LO_CHK = 5'd15;
  localparam logic [4:0] S_LW_STEP = 5'd16;
  localparam logic [4:0] S_LW_POP = 5'd17;
  localparam logic [4:0] S_LW_EDGE = 5'd18;
  localparam logic [4:0] S_LW_VIS = 5'd19;
  localparam logic [4:0] S_CN_RD = 5'd20;
  localparam logic [4:0] S_CN_CHK = 5'd21;
  localparam logic [4:0] S_QRY = 5'd22;
  localparam logic [4:0] S_OUT = 5'd23;

  localparam logic [PW-1:0] NULL_PTR = {1'b1, {HW{1'b0}}};

  typedef struct packed {
    logic [VW-1:0] v;
    logic [VW-1:0] par;
    logic          haspar;
    logic          skip;
    logic [PW-1:0] h;
    logic [TW-1:0] t0;
    logic [TW-1:0] t1;
  } frame_t;

  logic [4:0] state_r, state_nxt;
  logic [tecc_pkg::OPW-1:0] op_r, op_nxt;
  logic [FW-1:0] a_r, a_nxt, b_r, b_nxt, q_r, q_nxt;
  logic [FW-1:0] vc_r, vc_nxt;
  logic [EW-1:0] edges_r, edges_nxt;
  logic run_done_r, run_done_nxt;
  logic [TW-1:0] tc_r, tc_nxt, lc_r, lc_nxt, cnt_r, cnt_nxt;
  logic [LW-1:0] i_r, i_nxt;
  logic [VW-1:0] ci_r, ci_nxt, u_r, u_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  frame_t top_r, top_nxt;
  logic [tecc_pkg::STW-1:0] res_st_r, res_st_nxt, out_st_r, out_st_nxt;
  logic [TW-1:0] res_cnt_r, res_cnt_nxt, res_lab_r, res_lab_nxt;
  logic [TW-1:0] out_cnt_r, out_cnt_nxt, out_lab_r, out_lab_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [PW-1:0] first_mem [MAX_VERTICES];
  logic [PW-1:0] last_mem [MAX_VERTICES];
  logic [PW-1:0] nxt_mem [2*MAX_EDGES];
  logic [VW-1:0] tgt_mem [2*MAX_EDGES];
  logic [TW-1:0] ent_mem [MAX_VERTICES];
  logic [TW-1:0] low_mem [MAX_VERTICES];
  logic [TW-1:0] lab_mem [MAX_VERTICES];
  frame_t stk_mem [MAX_VERTICES];

  logic first_we, last_we, nxt_we, tgt_we, ent_we, low_we, lab_we, stk_we;
  logic [VW-1:0] first_wa, first_ra, last_wa, last_ra, ent_wa, ent_ra;
  logic [VW-1:0] low_wa, low_ra, lab_wa, lab_ra, stk_wa, stk_ra;
  logic [HW-1:0] nxt_wa, nxt_ra, tgt_wa, tgt_ra;
  logic [PW-1:0] first_wd, last_wd, nxt_wd;
  logic [VW-1:0] tgt_wd;
  logic [TW-1:0] ent_wd, low_wd, lab_wd;
  frame_t stk_wd;
  logic [PW-1:0] first_rd_r, last_rd_r, nxt_rd_r;
  logic [VW-1:0] tgt_rd_r;
  logic [TW-1:0] ent_rd_r, low_rd_r, lab_rd_r;
  frame_t stk_rd_r;

  logic [TW-1:0] cmp_x, cmp_y;
  tecc_pkg::cmp_res_t cmp_res;

  logic [LW-1:0] n_w, a_ext, b_ext, q_ext;
  logic [VW-1:0] a_v, b_v, q_v, i_v;
  logic a_ok, b_ok, q_ok;
  logic [HW-1:0] h0, h1;
  logic [TW-1:0] tc_inc, lc_inc, new_lab;

  tecc_cmp u_cmp (
    .x   (cmp_x),
    .y   (cmp_y),
    .res (cmp_res)
  );

  always_ff @(posedge clk) begin
    if (first_we) first_mem[first_wa] <= first_wd;
    first_rd_r <= first_mem[first_ra];
  end

  always_ff @(posedge clk) begin
    if (last_we) last_mem[last_wa] <= last_wd;
    last_rd_r <= last_mem[last_ra];
  end

  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    nxt_rd_r <= nxt_mem[nxt_ra];
  end

  always_ff @(posedge clk) begin
    if (tgt_we) tgt_mem[tgt_wa] <= tgt_wd;
    tgt_rd_r <= tgt_mem[tgt_ra];
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    ent_rd_r <= ent_mem[ent_ra];
  end

  always_ff @(posedge clk) begin
    if (low_we) low_mem[low_wa] <= low_wd;
    low_rd_r <= low_mem[low_ra];
  end

  always_ff @(posedge clk) begin
    if (lab_we) lab_mem[lab_wa] <= lab_wd;
    lab_rd_r <= lab_mem[lab_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_rd_r <= stk_mem[stk_ra];
  end

  always_comb begin
    n_w = (LW'(vc_r) > LW'(MAX_VERTICES)) ? LW'(MAX_VERTICES) : LW'(vc_r);
    a_ext = LW'(a_r) - LW'(1);
    b_ext = LW'(b_r) - LW'(1);
    q_ext = LW'(q_r) - LW'(1);
    a_v = a_ext[VW-1:0];
    b_v = b_ext[VW-1:0];
    q_v = q_ext[VW-1:0];
    i_v = i_r[VW-1:0];
    a_ok = (a_r != '0) && (LW'(a_r) <= n_w);
    b_ok = (b_r != '0) && (LW'(b_r) <= n_w);
    q_ok = (q_r != '0) && (LW'(q_r) <= n_w);
    h0 = HW'(edges_r) << 1;
    h1 = h0 | HW'(1);
    tc_inc = tc_r + TW'(1);
    lc_inc = lc_r + TW'(1);
    new_lab = cmp_res.lt ? lc_inc : top_r.t1;
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    a_nxt = a_r;
    b_nxt = b_r;
    q_nxt = q_r;
    vc_nxt = cfg_wr_en ? cfg_wr_data : vc_r;
    edges_nxt = edges_r;
    run_done_nxt = run_done_r;
    tc_nxt = tc_r;
    lc_nxt = lc_r;
    cnt_nxt = cnt_r;
    i_nxt = i_r;
    ci_nxt = ci_r;
    u_nxt = u_r;
    sp_nxt = sp_r;
    top_nxt = top_r;
    res_st_nxt = res_st_r;
    res_cnt_nxt = res_cnt_r;
    res_lab_nxt = res_lab_r;
    out_st_nxt = out_st_r;
    out_cnt_nxt = out_cnt_r;
    out_lab_nxt = out_lab_r;
    out_valid_nxt = out_valid_r && !out_tready;

    first_we = 1'b0; first_wa = '0; first_wd = NULL_PTR; first_ra = '0;
    last_we = 1'b0; last_wa = '0; last_wd = NULL_PTR; last_ra = '0;
    nxt_we = 1'b0; nxt_wa = '0; nxt_wd = NULL_PTR; nxt_ra = '0;
    tgt_we = 1'b0; tgt_wa = '0; tgt_wd = '0; tgt_ra = '0;
    ent_we = 1'b0; ent_wa = '0; ent_wd = '0; ent_ra = '0;
    low_we = 1'b0; low_wa = '0; low_wd = '0; low_ra = '0;
    lab_we = 1'b0; lab_wa = '0; lab_wd = '0; lab_ra = '0;
    stk_we = 1'b0; stk_wa = '0; stk_wd = top_r; stk_ra = '0;
    cmp_x = top_r.t0;
    cmp_y = stk_rd_r.t0;

    case (state_r)
      S_INIT: begin
        first_we = 1'b1; first_wa = ci_r;
        last_we = 1'b1; last_wa = ci_r;
        if (ci_r == VW'(MAX_VERTICES - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          ci_nxt = ci_r + VW'(1);
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt = in_tuser;
          a_nxt = in_tdata[14:0];
          b_nxt = in_tdata[29:15];
          q_nxt = in_tdata[44:30];
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        res_cnt_nxt = '0;
        res_lab_nxt = '0;
        res_st_nxt = tecc_pkg::ST_OK;
        case (op_r)
          tecc_pkg::OP_ADD: begin
            if (!(a_ok && b_ok)) begin
              res_st_nxt = tecc_pkg::ST_RANGE;
              state_nxt = S_OUT;
            end else if (edges_r == EW'(MAX_EDGES)) begin
              res_st_nxt = tecc_pkg::ST_FULL;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_ADD0;
            end
          end
          tecc_pkg::OP_RUN: begin
            ci_nxt = '0;
            state_nxt = S_RCLR;
          end
          tecc_pkg::OP_READ: begin
            if (!run_done_r) begin
              res_st_nxt = tecc_pkg::ST_NOT_RUN;
              state_nxt = S_OUT;
            end else if (!q_ok) begin
              res_st_nxt = tecc_pkg::ST_RANGE;
              state_nxt = S_OUT;
            end else begin
              lab_ra = q_v;
              state_nxt = S_QRY;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_QRY: begin
        res_lab_nxt = lab_rd_r;
        state_nxt = S_OUT;
      end
      S_ADD0: begin
        last_ra = a_v;
        tgt_we = 1'b1; tgt_wa = h0; tgt_wd = b_v;
        nxt_we = 1'b1; nxt_wa = h0; nxt_wd = NULL_PTR;
        state_nxt = S_ADD1;
      end
      S_ADD1: begin
        if (last_rd_r[HW]) begin
          first_we = 1'b1; first_wa = a_v; first_wd = PW'(h0);
        end else begin
          nxt_we = 1'b1; nxt_wa = last_rd_r[HW-1:0]; nxt_wd = PW'(h0);
        end
        last_we = 1'b1; last_wa = a_v; last_wd = PW'(h0);
        state_nxt = S_ADD2;
      end
      S_ADD2: begin
        last_ra = b_v;
        tgt_we = 1'b1; tgt_wa = h1; tgt_wd = a_v;
        nxt_we = 1'b1; nxt_wa = h1; nxt_wd = NULL_PTR;
        state_nxt = S_ADD3;
      end
      S_ADD3: begin
        if (last_rd_r[HW]) begin
          first_we = 1'b1; first_wa = b_v; first_wd = PW'(h1);
        end else begin
          nxt_we = 1'b1; nxt_wa = last_rd_r[HW-1:0]; nxt_wd = PW'(h1);
        end
        last_we = 1'b1; last_wa = b_v; last_wd = PW'(h1);
        edges_nxt = edges_r + EW'(1);
        state_nxt = S_OUT;
      end
      S_RCLR: begin
        ent_we = 1'b1; ent_wa = ci_r; ent_wd = '0;
        lab_we = 1'b1; lab_wa = ci_r; lab_wd = '0;
        if (ci_r == VW'(MAX_VERTICES - 1)) begin
          tc_nxt = '0;
          lc_nxt = '0;
          i_nxt = '0;
          state_nxt = S_TO_RD;
        end else begin
          ci_nxt = ci_r + VW'(1);
        end
      end
      S_TO_RD: begin
        if (i_r == n_w) begin
          i_nxt = '0;
          state_nxt = S_LO_RD;
        end else begin
          ent_ra = i_v;
          first_ra = i_v;
          state_nxt = S_TO_CHK;
        end
      end
      S_TO_CHK: begin
        if (ent_rd_r != '0) begin
          i_nxt = i_r + LW'(1);
          state_nxt = S_TO_RD;
        end else begin
          tc_nxt = tc_inc;
          ent_we = 1'b1; ent_wa = i_v; ent_wd = tc_inc;
          low_we = 1'b1; low_wa = i_v; low_wd = tc_inc;
          top_nxt = '{v: i_v, par: '0, haspar: 1'b0, skip: 1'b0, h: first_rd_r,
                      t0: tc_inc, t1: '0};
          sp_nxt = SPW'(1);
          state_nxt = S_TW_STEP;
        end
      end
      S_TW_STEP: begin
        if (top_r.h[HW]) begin
          if (sp_r == SPW'(1)) begin
            i_nxt = i_r + LW'(1);
            state_nxt = S_TO_RD;
          end else begin
            stk_ra = VW'(sp_r - SPW'(2));
            state_nxt = S_TW_POP;
          end
        end else begin
          nxt_ra = top_r.h[HW-1:0];
          tgt_ra = top_r.h[HW-1:0];
          state_nxt = S_TW_EDGE;
        end
      end
      S_TW_POP: begin
        cmp_x = top_r.t0;
        cmp_y = stk_rd_r.t0;
        top_nxt = stk_rd_r;
        top_nxt.t0 = cmp_res.mn;
        low_we = 1'b1; low_wa = stk_rd_r.v; low_wd = cmp_res.mn;
        sp_nxt = sp_r - SPW'(1);
        state_nxt = S_TW_STEP;
      end
      S_TW_EDGE: begin
        top_nxt.h = nxt_rd_r;
        if (top_r.haspar && (tgt_rd_r == top_r.par) && !top_r.skip) begin
          top_nxt.skip = 1'b1;
          state_nxt = S_TW_STEP;
        end else begin
          u_nxt = tgt_rd_r;
          ent_ra = tgt_rd_r;
          low_ra = tgt_rd_r;
          first_ra = tgt_rd_r;
          state_nxt = S_TW_VIS;
        end
      end
      S_TW_VIS: begin
        cmp_x = low_rd_r;
        cmp_y = top_r.t0;
        if (ent_rd_r != '0) begin
          top_nxt.t0 = cmp_res.mn;
          low_we = 1'b1; low_wa = top_r.v; low_wd = cmp_res.mn;
        end else begin
          tc_nxt = tc_inc;
          ent_we = 1'b1; ent_wa = u_r; ent_wd = tc_inc;
          low_we = 1'b1; low_wa = u_r; low_wd = tc_inc;
          stk_we = 1'b1; stk_wa = VW'(sp_r - SPW'(1)); stk_wd = top_r;
          top_nxt = '{v: u_r, par: top_r.v, haspar: 1'b1, skip: 1'b0, h: first_rd_r,
                      t0: tc_inc, t1: '0};
          sp_nxt = sp_r + SPW'(1);
        end
        state_nxt = S_TW_STEP;
      end
      S_LO_RD: begin
        if (i_r == n_w) begin
          i_nxt = '0;
          cnt_nxt = '0;
          state_nxt = S_CN_RD;
        end else begin
          lab_ra = i_v;
          ent_ra = i_v;
          first_ra = i_v;
          state_nxt = S_LO_CHK;
        end
      end
      S_LO_CHK: begin
        if (lab_rd_r != '0) begin
          i_nxt = i_r + LW'(1);
          state_nxt = S_LO_RD;
        end else begin
          lc_nxt = lc_inc;
          lab_we = 1'b1; lab_wa = i_v; lab_wd = lc_inc;
          top_nxt = '{v: i_v, par: '0, haspar: 1'b0, skip: 1'b0, h: first_rd_r,
                      t0: ent_rd_r, t1: lc_inc};
          sp_nxt = SPW'(1);
          state_nxt = S_LW_STEP;
        end
      end
      S_LW_STEP: begin
        if (top_r.h[HW]) begin
          if (sp_r == SPW'(1)) begin
            i_nxt = i_r + LW'(1);
            state_nxt = S_LO_RD;
          end else begin
            stk_ra = VW'(sp_r - SPW'(2));
            state_nxt = S_LW_POP;
          end
        end else begin
          nxt_ra = top_r.h[HW-1:0];
          tgt_ra = top_r.h[HW-1:0];
          state_nxt = S_LW_EDGE;
        end
      end
      S_LW_POP: begin
        top_nxt = stk_rd_r;
        sp_nxt = sp_r - SPW'(1);
        state_nxt = S_LW_STEP;
      end
      S_LW_EDGE: begin
        top_nxt.h = nxt_rd_r;
        u_nxt = tgt_rd_r;
        lab_ra = tgt_rd_r;
        low_ra = tgt_rd_r;
        ent_ra = tgt_rd_r;
        first_ra = tgt_rd_r;
        state_nxt = S_LW_VIS;
      end
      S_LW_VIS: begin
        cmp_x = top_r.t0;
        cmp_y = low_rd_r;
        if (lab_rd_r == '0) begin
          if (cmp_res.lt) begin
            lc_nxt = lc_inc;
          end
          lab_we = 1'b1; lab_wa = u_r; lab_wd = new_lab;
          stk_we = 1'b1; stk_wa = VW'(sp_r - SPW'(1)); stk_wd = top_r;
          top_nxt = '{v: u_r, par: top_r.v, haspar: 1'b1, skip: 1'b0, h: first_rd_r,
                      t0: ent_rd_r, t1: new_lab};
          sp_nxt = sp_r + SPW'(1);
        end
        state_nxt = S_LW_STEP;
      end
      S_CN_RD: begin
        if (i_r == n_w) begin
          run_done_nxt = 1'b1;
          res_cnt_nxt = cnt_r;
          state_nxt = S_OUT;
        end else begin
          lab_ra = i_v;
          state_nxt = S_CN_CHK;
        end
      end
      S_CN_CHK: begin
        cmp_x = cnt_r;
        cmp_y = lab_rd_r;
        if (cmp_res.lt) begin
          cnt_nxt = lab_rd_r;
        end
        i_nxt = i_r + LW'(1);
        state_nxt = S_CN_RD;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt = res_st_r;
          out_cnt_nxt = res_cnt_r;
          out_lab_nxt = res_lab_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      ci_r <= '0;
      vc_r <= FW'(1);
      edges_r <= '0;
      run_done_r <= 1'b0;
      tc_r <= '0;
      lc_r <= '0;
      i_r <= '0;
      sp_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ci_r <= ci_nxt;
      vc_r <= vc_nxt;
      edges_r <= edges_nxt;
      run_done_r <= run_done_nxt;
      tc_r <= tc_nxt;
      lc_r <= lc_nxt;
      i_r <= i_nxt;
      sp_r <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    q_r <= q_nxt;
    cnt_r <= cnt_nxt;
    u_r <= u_nxt;
    top_r <= top_nxt;
    res_st_r <= res_st_nxt;
    res_cnt_r <= res_cnt_nxt;
    res_lab_r <= res_lab_nxt;
    out_st_r <= out_st_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_lab_r <= out_lab_nxt;
  end

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser = out_st_r;
  assign out_tdata = {2'b00, out_lab_r, out_cnt_r};

`ifndef SYNTH
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> !in_tready) else $error("ready raised while a result is pending");
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(MAX_VERTICES)) else $error("walk stack overflow");
  a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    edges_r <= EW'(MAX_EDGES)) else $error("edge count beyond store");
  a_not_run_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == tecc_pkg::ST_NOT_RUN)) |-> (out_tdata == '0))
    else $error("not-run result carries data");
  a_done_after_count: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(run_done_r) |-> ($past(state_r) == S_CN_RD)) else $error("run flag set outside count");
`endif

endmodule

// ===== dv/two_edge_connected_components_tb.sv =====
// Testbench for the labeler of components left once all bridges are cut, checked by a scoreboard.
module two_edge_connected_components_tb;

  localparam int NV = 16384;
  localparam int NE = 32768;
  localparam int NH = 2 * NE;
  localparam int unsigned NO_EDGE = 32'hFFFF_FFFF;
  localparam logic [tecc_pkg::OPW-1:0] OP_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [tecc_pkg::FW-1:0] cfg_wr_data;
  logic in_tvalid;
  logic in_tready;
  logic [tecc_pkg::IN_DW-1:0] in_tdata;
  logic [tecc_pkg::OPW-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [tecc_pkg::OUT_DW-1:0] out_tdata;
  logic [tecc_pkg::STW-1:0] out_tuser;

  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  typedef struct {
    logic [tecc_pkg::STW-1:0] status;
    logic [tecc_pkg::FW-1:0] count;
    logic [tecc_pkg::FW-1:0] vlabel;
  } answer_t;

  task automatic report(input string what);
    errors++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  class label_scoreboard;
    int unsigned vcount = 1;
    int unsigned first_half[NV];
    int unsigned last_half[NV];
    int unsigned next_half[NH];
    int unsigned target[NH];
    int unsigned loaded = 0;
    int unsigned t_in[NV];
    int unsigned t_low[NV];
    int unsigned comp[NV];
    int unsigned stk_v[NV];
    int unsigned stk_h[NV];
    bit stk_skip[NV];
    int unsigned clock_t;
    int unsigned comp_ctr;
    bit labelled = 0;
    answer_t answers[$];

    function new();
      for (int i = 0; i < NV; i++) begin
        first_half[i] = NO_EDGE;
        last_half[i] = NO_EDGE;
        t_in[i] = 0;
        t_low[i] = 0;
        comp[i] = 0;
      end
    endfunction

    function int unsigned live_n();
      return vcount > NV ? NV : vcount;
    endfunction

    function void link(int unsigned from, int unsigned to, int unsigned h);
      target[h] = to;
      next_half[h] = NO_EDGE;
      if (last_half[from] == NO_EDGE) first_half[from] = h;
      else next_half[last_half[from]] = h;
      last_half[from] = h;
    endfunction

    function void push(ref int unsigned sp, input int unsigned v);
      if (sp >= NV) return;
      stk_v[sp] = v;
      stk_h[sp] = first_half[v];
      stk_skip[sp] = 0;
      sp++;
    endfunction

    function void time_dfs(int unsigned root);
      int unsigned sp, top, v, h, u, p;
      sp = 0;
      clock_t++;
      t_in[root] = clock_t;
      t_low[root] = clock_t;
      push(sp, root);
      while (sp > 0) begin
        top = sp - 1;
        v = stk_v[top];
        h = stk_h[top];
        if (h >= NH) begin
          sp--;
          if (sp > 0) begin
            p = stk_v[sp - 1];
            if (t_low[v] < t_low[p]) t_low[p] = t_low[v];
          end
          continue;
        end
        stk_h[top] = next_half[h];
        u = target[h];
        if (top > 0 && u == stk_v[top - 1] && !stk_skip[top]) begin
          stk_skip[top] = 1;
          continue;
        end
        if (t_in[u] != 0) begin
          if (t_low[u] < t_low[v]) t_low[v] = t_low[u];
        end else begin
          clock_t++;
          t_in[u] = clock_t;
          t_low[u] = clock_t;
          push(sp, u);
        end
      end
    endfunction

    function void label_dfs(int unsigned root);
      int unsigned sp, top, v, h, u;
      sp = 0;
      comp_ctr++;
      comp[root] = comp_ctr;
      push(sp, root);
      while (sp > 0) begin
        top = sp - 1;
        v = stk_v[top];
        h = stk_h[top];
        if (h >= NH) begin
          sp--;
          continue;
        end
        stk_h[top] = next_half[h];
        u = target[h];
        if (comp[u] != 0) continue;
        if (t_low[u] > t_in[v]) begin
          comp_ctr++;
          comp[u] = comp_ctr;
        end else begin
          comp[u] = comp[v];
        end
        push(sp, u);
      end
    endfunction

    function void note(logic [tecc_pkg::OPW-1:0] op, int unsigned a, int unsigned b,
                       int unsigned q);
      answer_t r;
      int unsigned n, best;
      n = live_n();
      r.status = tecc_pkg::ST_OK;
      r.count = '0;
      r.vlabel = '0;
      if (op == tecc_pkg::OP_ADD) begin
        if (a < 1 || a > n || b < 1 || b > n) r.status = tecc_pkg::ST_RANGE;
        else if (loaded >= NE) r.status = tecc_pkg::ST_FULL;
        else begin
          link(a - 1, b - 1, 2 * loaded);
          link(b - 1, a - 1, 2 * loaded + 1);
          loaded++;
        end
      end else if (op == tecc_pkg::OP_RUN) begin
        for (int i = 0; i < NV; i++) begin
          t_in[i] = 0;
          t_low[i] = 0;
          comp[i] = 0;
        end
        clock_t = 0;
        comp_ctr = 0;
        best = 0;
        for (int unsigned i = 0; i < n; i++) if (t_in[i] == 0) time_dfs(i);
        for (int unsigned i = 0; i < n; i++) if (comp[i] == 0) label_dfs(i);
        for (int unsigned i = 0; i < n; i++) if (comp[i] > best) best = comp[i];
        r.count = best[tecc_pkg::FW-1:0];
        labelled = 1;
      end else if (op == tecc_pkg::OP_READ) begin
        if (!labelled) r.status = tecc_pkg::ST_NOT_RUN;
        else if (q < 1 || q > n) r.status = tecc_pkg::ST_RANGE;
        else r.vlabel = comp[q - 1][tecc_pkg::FW-1:0];
      end else begin
        return;
      end
      answers = {answers, r};
    endfunction

    task check(logic [tecc_pkg::STW-1:0] status, logic [tecc_pkg::OUT_DW-1:0] data);
      answer_t e;
      if (answers.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      e = answers.pop_front();
      if (status !== e.status)
        report($sformatf("status %0d, expected %0d", status, e.status));
      if (data[tecc_pkg::FW-1:0] !== e.count)
        report($sformatf("component_count %0d, expected %0d", data[tecc_pkg::FW-1:0],
                         e.count));
      if (data[2*tecc_pkg::FW-1:tecc_pkg::FW] !== e.vlabel)
        report($sformatf("vertex_label %0d, expected %0d",
                         data[2*tecc_pkg::FW-1:tecc_pkg::FW], e.vlabel));
    endtask
  endclass

  label_scoreboard sb = new();

  two_edge_connected_components u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note(in_tuser, in_tdata[tecc_pkg::FW-1:0],
                in_tdata[2*tecc_pkg::FW-1:tecc_pkg::FW],
                in_tdata[3*tecc_pkg::FW-1:2*tecc_pkg::FW]);
      if (out_tvalid && out_tready) sb.check(out_tuser, out_tdata);
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send(input logic [tecc_pkg::OPW-1:0] op, input int unsigned a,
                      input int unsigned b, input int unsigned q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = '0;
    in_tdata[tecc_pkg::FW-1:0] = a[tecc_pkg::FW-1:0];
    in_tdata[2*tecc_pkg::FW-1:tecc_pkg::FW] = b[tecc_pkg::FW-1:0];
    in_tdata[3*tecc_pkg::FW-1:2*tecc_pkg::FW] = q[tecc_pkg::FW-1:0];
    while (!in_tready) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (sb.answers.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_vertices(input int unsigned v);
    drain();
    cfg_wr_en = 1'b1;
    cfg_wr_data = v[tecc_pkg::FW-1:0];
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.vcount = v & 32'h7FFF;
  endtask

  task automatic set_mode(input int m);
    case (m % 4)
      0: begin send_idle_pct = 0; recv_stall_pct = 0; end
      1: begin send_idle_pct = 81; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 81; end
      default: begin send_idle_pct = 35; recv_stall_pct = 35; end
    endcase
  endtask

  function automatic int unsigned pick_vertex(int unsigned n);
    if ($urandom_range(99) < 8) return $urandom_range(32767);
    return $urandom_range(n, 1);
  endfunction

  initial begin
    int unsigned sizes[8] = '{1, 2, 5, 12, 30, 60, 16384, 0};
    int unsigned n, k;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = tecc_pkg::OP_ADD;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    send(tecc_pkg::OP_READ, 0, 0, 1);
    send(tecc_pkg::OP_ADD, 1, 1, 0);
    send(tecc_pkg::OP_ADD, 1, 2, 0);
    send(tecc_pkg::OP_ADD, 0, 1, 0);
    send(OP_UNUSED, 32767, 32767, 32767);
    send(tecc_pkg::OP_RUN, 0, 0, 0);
    send(tecc_pkg::OP_READ, 0, 0, 1);
    send(tecc_pkg::OP_READ, 0, 0, 0);
    set_vertices(6);
    send(tecc_pkg::OP_ADD, 1, 2, 0);
    send(tecc_pkg::OP_ADD, 2, 3, 0);
    send(tecc_pkg::OP_ADD, 3, 1, 0);
    send(tecc_pkg::OP_ADD, 3, 4, 0);
    send(tecc_pkg::OP_ADD, 4, 5, 0);
    send(tecc_pkg::OP_ADD, 5, 4, 0);
    send(tecc_pkg::OP_RUN, 0, 0, 0);
    for (int v = 1; v <= 7; v++) send(tecc_pkg::OP_READ, 0, 0, v);
    send(tecc_pkg::OP_ADD, 5, 6, 0);
    send(tecc_pkg::OP_READ, 0, 0, 6);
    set_vertices(3);
    send(tecc_pkg::OP_RUN, 0, 0, 0);
    send(tecc_pkg::OP_READ, 0, 0, 3);
    set_vertices(32767);
    send(tecc_pkg::OP_ADD, 16384, 32767, 0);
    send(tecc_pkg::OP_ADD, 16384, 1, 0);
    send(tecc_pkg::OP_RUN, 0, 0, 0);
    send(tecc_pkg::OP_READ, 0, 0, 16384);
    set_vertices(0);
    send(tecc_pkg::OP_RUN, 0, 0, 0);
    send(tecc_pkg::OP_READ, 0, 0, 1);

    for (int ph = 0; ph < 10; ph++) begin
      n = (ph < 7) ? sizes[ph] : $urandom_range(200, 1);
      set_vertices(n);
      set_mode(ph);
      for (int i = 0; i < 130; i++) begin
        if (i % 40 == 20) set_mode($urandom_range(3));
        k = $urandom_range(99);
        if (i == 64 || i == 129) send(tecc_pkg::OP_RUN, $urandom, $urandom, $urandom);
        else if (k < 70) begin
          if (n == 16384 && k < 40)
            send(tecc_pkg::OP_ADD, $urandom_range(16384, 16370), $urandom_range(16384, 16370),
                 $urandom);
          else send(tecc_pkg::OP_ADD, pick_vertex(n), pick_vertex(n), $urandom);
        end else if (k < 96) send(tecc_pkg::OP_READ, $urandom, $urandom, pick_vertex(n));
        else send(OP_UNUSED, $urandom, $urandom, $urandom);
      end
      for (int i = 0; i < 6; i++) send(tecc_pkg::OP_READ, 0, 0, pick_vertex(n));
    end

    set_vertices(4);
    set_mode(0);
    send(tecc_pkg::OP_ADD, 1, 2, 0);
    send(tecc_pkg::OP_ADD, 9, 2, 0);
    send(tecc_pkg::OP_ADD, 4, 4, 0);
    send(tecc_pkg::OP_READ, 0, 0, 2);

    drain();
    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
